// ===== rtl/wsld_pkg.sv =====
package wsld_pkg;

   localparam int unsigned SIZE_W = 31;
   localparam int unsigned ACC_W = SIZE_W + 7;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned LBYTES_W = 4;

   localparam logic [LBYTES_W-1:0] MAX_LENGTH_BYTES = 4'd8;
   localparam logic [SIZE_W-1:0] MAX_FRAME_SIZE_RESET = 31'd16384;

   localparam logic [7:0] BINARY_FLAG = 8'h80;
   localparam logic [7:0] DELIMITER = 8'hFF;
   localparam logic [7:0] CLOSE_TYPE = 8'hFF;

   typedef enum logic [2:0] {
      PH_TYPE,
      PH_BLEN,
      PH_BDATA,
      PH_TEXT,
      PH_HALT,
      PH_CLOSED
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LONG  = 2'd1,
      ST_LEN_FIELD = 2'd2,
      ST_CLOSE     = 2'd3
   } status_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] frame_type;
      logic [7:0] payload_byte;
      logic       has_data;
      logic       frame_first;
      logic       frame_last;
      status_type status;
   } result_type;

endpackage

// ===== rtl/websocket_legacy_frame_decoder_top.sv =====
// Legacy WebSocket frame decoder: takes one received byte per item on req_ and
// gives at most one result item on rsp_ for it. A new byte is taken every cycle
// while the result register is empty or being drained, so the sustained rate is
// one item per cycle; each byte passes the frame parser in the cycle it is taken
// and its result sits in the rsp_ register from the next cycle on. After a
// length error the block ignores all input until reset, and after a closing
// handshake (binary type 0xFF with length 0) it discards all input until reset.
// The frame size limit is written over csr_, which is always ready; the user must
// write it only while the block is idle, as the block itself does not enforce this.
module websocket_legacy_frame_decoder_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // rx_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata,   // frame_type, payload_byte, frame_first, zero fill
   output logic                        rsp_tlast,   // frame_last
   output logic [2:0]                  rsp_tuser,   // has_data, status
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [wsld_pkg::SIZE_W-1:0] csr_data
);

   logic [wsld_pkg::SIZE_W-1:0] max_size_ff;
   logic                        out_valid_ff, out_valid_in;
   wsld_pkg::result_type        out_ff;
   wsld_pkg::result_type        result;
   logic                        step;

   assign csr_ready  = 1'b1;
   assign req_tready = !out_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   wsld_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .rx_byte        (req_tdata),
      .max_frame_size (max_size_ff),
      .result         (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = result.valid;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff  <= wsld_pkg::MAX_FRAME_SIZE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            max_size_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.valid) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff.frame_first, out_ff.payload_byte, out_ff.frame_type};
   assign rsp_tlast  = out_ff.frame_last;
   assign rsp_tuser  = {out_ff.status, out_ff.has_data};

endmodule

// ===== rtl/wsld_parser.sv =====
module wsld_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [7:0]                    rx_byte,
   input  logic [wsld_pkg::SIZE_W-1:0]   max_frame_size,
   output wsld_pkg::result_type          result
);

   wsld_pkg::phase_type                 phase_ff, phase_in;
   logic [7:0]                          type_ff, type_in;
   logic [wsld_pkg::SIZE_W-1:0]         acc_ff, acc_in;
   logic [wsld_pkg::LBYTES_W-1:0]       lcnt_ff, lcnt_in;
   logic [wsld_pkg::COUNT_W-1:0]        pcnt_ff, pcnt_in;
   logic                                first_ff, first_in;

   logic [wsld_pkg::ACC_W-1:0]          acc_shift;
   logic                                acc_too_big;
   logic [wsld_pkg::LBYTES_W-1:0]       lcnt_inc;
   logic                                lcnt_over;
   logic [wsld_pkg::COUNT_W-1:0]        pcnt_inc;
   logic                                text_too_big;
   logic                                bdata_last;

   assign acc_shift    = {acc_ff, rx_byte[6:0]};
   assign acc_too_big  = acc_shift > {7'd0, max_frame_size};
   assign lcnt_inc     = lcnt_ff + 1'b1;
   assign lcnt_over    = lcnt_inc > wsld_pkg::MAX_LENGTH_BYTES;
   assign pcnt_inc     = pcnt_ff + 1'b1;
   assign text_too_big = pcnt_inc > {1'b0, max_frame_size};
   assign bdata_last   = pcnt_ff <= 32'd1;

   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      acc_in   = acc_ff;
      lcnt_in  = lcnt_ff;
      pcnt_in  = pcnt_ff;
      first_in = first_ff;
      case (phase_ff)
         wsld_pkg::PH_TYPE: begin
            type_in  = rx_byte;
            first_in = 1'b1;
            pcnt_in  = '0;
            acc_in   = '0;
            lcnt_in  = '0;
            phase_in = ((rx_byte & wsld_pkg::BINARY_FLAG) != 8'd0) ?
                       wsld_pkg::PH_BLEN : wsld_pkg::PH_TEXT;
         end
         wsld_pkg::PH_BLEN: begin
            acc_in  = acc_shift[wsld_pkg::SIZE_W-1:0];
            lcnt_in = lcnt_inc;
            if (acc_too_big || lcnt_over) begin
               phase_in = wsld_pkg::PH_HALT;
            end else if (!rx_byte[7]) begin
               if (acc_shift == '0) begin
                  phase_in = (type_ff == wsld_pkg::CLOSE_TYPE) ?
                             wsld_pkg::PH_CLOSED : wsld_pkg::PH_TYPE;
               end else begin
                  pcnt_in  = {1'b0, acc_shift[wsld_pkg::SIZE_W-1:0]};
                  first_in = 1'b1;
                  phase_in = wsld_pkg::PH_BDATA;
               end
            end
         end
         wsld_pkg::PH_BDATA: begin
            first_in = 1'b0;
            if (bdata_last) begin
               pcnt_in  = '0;
               phase_in = wsld_pkg::PH_TYPE;
            end else begin
               pcnt_in = pcnt_ff - 1'b1;
            end
         end
         wsld_pkg::PH_TEXT: begin
            if (rx_byte == wsld_pkg::DELIMITER) begin
               phase_in = wsld_pkg::PH_TYPE;
            end else begin
               pcnt_in = pcnt_inc;
               if (text_too_big) begin
                  phase_in = wsld_pkg::PH_HALT;
               end else begin
                  first_in = 1'b0;
               end
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_comb begin
      result              = '0;
      result.frame_type   = type_ff;
      result.status       = wsld_pkg::ST_OK;
      case (phase_ff)
         wsld_pkg::PH_BLEN: begin
            result.frame_last = 1'b1;
            if (acc_too_big) begin
               result.valid  = 1'b1;
               result.status = wsld_pkg::ST_TOO_LONG;
            end else if (lcnt_over) begin
               result.valid  = 1'b1;
               result.status = wsld_pkg::ST_LEN_FIELD;
            end else if (!rx_byte[7] && acc_shift == '0) begin
               result.valid       = 1'b1;
               result.frame_first = 1'b1;
               result.status      = (type_ff == wsld_pkg::CLOSE_TYPE) ?
                                    wsld_pkg::ST_CLOSE : wsld_pkg::ST_OK;
            end
         end
         wsld_pkg::PH_BDATA: begin
            result.valid        = 1'b1;
            result.payload_byte = rx_byte;
            result.has_data     = 1'b1;
            result.frame_first  = first_ff;
            result.frame_last   = bdata_last;
         end
         wsld_pkg::PH_TEXT: begin
            result.valid = 1'b1;
            if (rx_byte == wsld_pkg::DELIMITER) begin
               result.frame_first = first_ff;
               result.frame_last  = 1'b1;
            end else if (text_too_big) begin
               result.frame_last = 1'b1;
               result.status     = wsld_pkg::ST_TOO_LONG;
            end else begin
               result.payload_byte = rx_byte;
               result.has_data     = 1'b1;
               result.frame_first  = first_ff;
            end
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase
      result.valid = result.valid & step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wsld_pkg::PH_TYPE;
         type_ff  <= '0;
         acc_ff   <= '0;
         lcnt_ff  <= '0;
         pcnt_ff  <= '0;
         first_ff <= 1'b1;
      end else if (step) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         acc_ff   <= acc_in;
         lcnt_ff  <= lcnt_in;
         pcnt_ff  <= pcnt_in;
         first_ff <= first_in;
      end
   end

endmodule
